/* rtl/lnend_pkg.sv */
// lnend_pkg: shared types and constants for the line ending translator
// no dependencies
`default_nettype none

package lnend_pkg;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [1:0] ACT_DATA    = 2'd0;
    localparam logic [1:0] ACT_EOF     = 2'd1;
    localparam logic [1:0] ACT_DISCARD = 2'd2;

    localparam logic [2:0] MODE_DECODE = 3'd0;
    localparam logic [2:0] MODE_BINARY = 3'd1;
    localparam logic [2:0] MODE_CRLF   = 3'd2;
    localparam logic [2:0] MODE_LF     = 3'd3;
    localparam logic [2:0] MODE_CR     = 3'd4;

    typedef enum logic [2:0] {
        PEND_NONE = 3'b001,
        PEND_LF   = 3'b010,
        PEND_CR   = 3'b100
    } pend_t;

    // one or two result bytes caused by one input item
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } entry_t;

endpackage

`default_nettype wire

/* rtl/lnend_front.sv */
// lnend_front: accepts input items, holds mode and pending newline,
// classifies each item into zero, one or two result bytes; uses lnend_pkg
`default_nettype none

module lnend_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                translate_mode_we,
    input  wire logic [2:0]          translate_mode_wdata,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [1:0]          action,
    input  wire logic [7:0]          byte_in,
    input  wire logic                q_full,
    output logic                     q_wr,
    output lnend_pkg::entry_t        q_wdata
);

    logic [2:0]      mode_reg;
    lnend_pkg::pend_t pend_reg;
    lnend_pkg::pend_t pend_next;
    lnend_pkg::pend_t self_pend;
    logic            emit;
    logic            accept;
    logic            is_nl;

    assign full   = q_full;
    assign accept = push & ~q_full;
    assign is_nl  = (byte_in == lnend_pkg::CH_LF) || (byte_in == lnend_pkg::CH_CR);
    assign self_pend = (byte_in == lnend_pkg::CH_LF) ? lnend_pkg::PEND_LF
                                                     : lnend_pkg::PEND_CR;

    always_comb
    begin
        emit       = 1'b0;
        q_wdata.two = 1'b0;
        q_wdata.b0 = byte_in;
        q_wdata.b1 = byte_in;
        pend_next  = pend_reg;
        unique case (action)
            lnend_pkg::ACT_DATA:
            begin
                unique case (mode_reg)
                    lnend_pkg::MODE_DECODE:
                    begin
                        if (is_nl)
                        begin
                            if (pend_reg == lnend_pkg::PEND_NONE)
                            begin
                                pend_next = self_pend;
                            end
                            else
                            begin
                                emit       = 1'b1;
                                q_wdata.b0 = lnend_pkg::CH_LF;
                                pend_next  = (pend_reg == self_pend) ? self_pend
                                                                     : lnend_pkg::PEND_NONE;
                            end
                        end
                        else
                        begin
                            emit      = 1'b1;
                            pend_next = lnend_pkg::PEND_NONE;
                            if (pend_reg != lnend_pkg::PEND_NONE)
                            begin
                                q_wdata.two = 1'b1;
                                q_wdata.b0  = lnend_pkg::CH_LF;
                            end
                        end
                    end
                    lnend_pkg::MODE_CRLF:
                    begin
                        if (byte_in == lnend_pkg::CH_LF)
                        begin
                            emit        = 1'b1;
                            q_wdata.two = 1'b1;
                            q_wdata.b0  = lnend_pkg::CH_CR;
                        end
                        else if (byte_in != lnend_pkg::CH_CR)
                        begin
                            emit = 1'b1;
                        end
                    end
                    lnend_pkg::MODE_LF:
                    begin
                        emit = (byte_in != lnend_pkg::CH_CR);
                    end
                    lnend_pkg::MODE_CR:
                    begin
                        emit = (byte_in != lnend_pkg::CH_CR);
                        if (byte_in == lnend_pkg::CH_LF)
                        begin
                            q_wdata.b0 = lnend_pkg::CH_CR;
                        end
                    end
                    default:
                    begin
                        emit = 1'b1;
                    end
                endcase
            end
            lnend_pkg::ACT_EOF:
            begin
                pend_next = lnend_pkg::PEND_NONE;
                if ((mode_reg == lnend_pkg::MODE_DECODE)
                    && (pend_reg != lnend_pkg::PEND_NONE))
                begin
                    emit       = 1'b1;
                    q_wdata.b0 = lnend_pkg::CH_LF;
                end
            end
            lnend_pkg::ACT_DISCARD:
            begin
                pend_next = lnend_pkg::PEND_NONE;
            end
            default:
            begin
                pend_next = pend_reg;
            end
        endcase
    end

    assign q_wr = accept & emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= lnend_pkg::MODE_DECODE;
            pend_reg <= lnend_pkg::PEND_NONE;
        end
        else
        begin
            if (translate_mode_we)
            begin
                mode_reg <= translate_mode_wdata;
            end
            if (accept)
            begin
                pend_reg <= pend_next;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/lnend_fifo.sv */
// lnend_fifo: short queue of result entries between front and back
// uses lnend_pkg::entry_t
`default_nettype none

module lnend_fifo
#(
    parameter int DEPTH = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr,
    input  wire lnend_pkg::entry_t  wdata,
    output logic                    full,
    input  wire logic               rd,
    output lnend_pkg::entry_t       rdata,
    output logic                    empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    lnend_pkg::entry_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr & ~full;
    assign do_rd = rd & ~empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/lnend_back.sv */
// lnend_back: takes entries from the queue and delivers their bytes one a
// transfer from an output register; uses lnend_pkg::entry_t
`default_nettype none

module lnend_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire lnend_pkg::entry_t  q_rdata,
    output logic                    q_rd,
    output logic                    empty,
    input  wire logic               pop,
    output logic [7:0]              byte_out,
    output logic                    last
);

    lnend_pkg::entry_t cur_reg;
    lnend_pkg::entry_t cur_next;
    logic              valid_reg;
    logic              valid_next;
    logic              sel_reg;
    logic              sel_next;
    logic              advance;

    assign empty    = ~valid_reg;
    assign byte_out = sel_reg ? cur_reg.b1 : cur_reg.b0;
    assign last     = sel_reg | ~cur_reg.two;
    assign advance  = valid_reg & pop;

    always_comb
    begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        sel_next   = sel_reg;
        q_rd       = 1'b0;
        priority if (advance && !sel_reg && cur_reg.two)
        begin
            sel_next = 1'b1;
        end
        else if (!valid_reg || advance)
        begin
            q_rd       = ~q_empty;
            valid_next = ~q_empty;
            cur_next   = q_rdata;
            sel_next   = 1'b0;
        end
        else
        begin
            // output register holds while the receiver stalls
            q_rd = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/line_ending_translator.sv */
// line_ending_translator: top level, front classifier, entry queue, back serializer
// depends on lnend_pkg, lnend_front, lnend_fifo, lnend_back
//
// channel   direction  handshake                      payload
// config    in         translate_mode_we              translate_mode_wdata[2:0]
// input     in         push / full                    action[1:0], byte_in[7:0]
// result    out        empty / pop                    byte_out[7:0], last
//
// one input item can transfer each cycle while the queue has room
// result bytes transfer one a cycle from the back output register while the
// receiver pops; an item that makes two bytes holds the back for both of them,
// so the back sets the rate; results pass through the queue to that register
// asynchronous reset clears mode, pending newline, queue and output valid
`default_nettype none

module line_ending_translator
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       translate_mode_we,
    input  wire logic [2:0] translate_mode_wdata,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] action,
    input  wire logic [7:0] byte_in,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      byte_out,
    output logic            last
);

    logic              q_wr;
    logic              q_full;
    logic              q_rd;
    logic              q_empty;
    lnend_pkg::entry_t q_wdata;
    lnend_pkg::entry_t q_rdata;

    lnend_front u_front
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .translate_mode_we    (translate_mode_we),
        .translate_mode_wdata (translate_mode_wdata),
        .push                 (push),
        .full                 (full),
        .action               (action),
        .byte_in              (byte_in),
        .q_full               (q_full),
        .q_wr                 (q_wr),
        .q_wdata              (q_wdata)
    );

    lnend_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    lnend_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_rdata  (q_rdata),
        .q_rd     (q_rd),
        .empty    (empty),
        .pop      (pop),
        .byte_out (byte_out),
        .last     (last)
    );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking bench for line_ending_translator, directed table then random phases
// depends on lnend_pkg and line_ending_translator; a local line ending model predicts untyped items

module testbench;

    localparam logic [7:0] CH_LF       = lnend_pkg::CH_LF;
    localparam logic [7:0] CH_CR       = lnend_pkg::CH_CR;
    localparam logic [1:0] ACT_DATA    = lnend_pkg::ACT_DATA;
    localparam logic [1:0] ACT_EOF     = lnend_pkg::ACT_EOF;
    localparam logic [1:0] ACT_DISCARD = lnend_pkg::ACT_DISCARD;
    localparam logic [2:0] MODE_DECODE = lnend_pkg::MODE_DECODE;
    localparam logic [2:0] MODE_BINARY = lnend_pkg::MODE_BINARY;
    localparam logic [2:0] MODE_CRLF   = lnend_pkg::MODE_CRLF;
    localparam logic [2:0] MODE_LF     = lnend_pkg::MODE_LF;
    localparam logic [2:0] MODE_CR     = lnend_pkg::MODE_CR;

    localparam int CLK_HALF    = 5;
    localparam int SEG_COUNT   = 11;
    localparam int SEG_ITEMS   = 91;
    localparam int SETTLE      = 8;
    localparam int WATCHDOG_NS = 2_000_000;

    localparam logic [1:0] ACT_RSVD   = 2'd3;
    localparam logic [2:0] MODE_RSVD5 = 3'd5;
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    typedef enum logic [1:0] {
        HELD_NONE,
        HELD_LF,
        HELD_CR
    } held_t;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last_flag;
    } out_byte_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] act;
        logic [7:0] data;
        logic       known;
        logic [1:0] cnt;
        logic [7:0] e0;
        logic [7:0] e1;
    } step_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       translate_mode_we = 1'b0;
    logic [2:0] translate_mode_wdata = MODE_DECODE;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] action = ACT_DATA;
    logic [7:0] byte_in = 8'h00;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] byte_out;
    logic       last;

    // typed expectation travels with a directed item
    logic       row_known = 1'b0;
    logic [1:0] row_cnt = 2'd0;
    logic [7:0] row_e0 = 8'h00;
    logic [7:0] row_e1 = 8'h00;

    logic [2:0] model_mode = MODE_DECODE;
    held_t      held_nl = HELD_NONE;
    out_byte_t  out_bytes_q[$];
    step_t      directed_q[$];
    int         mismatch_cnt = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;

    line_ending_translator uut
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .translate_mode_we    (translate_mode_we),
        .translate_mode_wdata (translate_mode_wdata),
        .push                 (push),
        .full                 (full),
        .action               (action),
        .byte_in              (byte_in),
        .empty                (empty),
        .pop                  (pop),
        .byte_out             (byte_out),
        .last                 (last)
    );

    always #CLK_HALF clk = ~clk;

    function automatic void predict_translation(input logic [1:0] act, input logic [7:0] b,
                                                output logic [1:0] cnt, output logic [7:0] r0,
                                                output logic [7:0] r1);
        held_t self_nl;
        cnt = 2'd0;
        r0 = 8'h00;
        r1 = 8'h00;
        self_nl = (b == CH_LF) ? HELD_LF : HELD_CR;
        case (act)
            ACT_EOF:
            begin
                if (model_mode == MODE_DECODE && held_nl != HELD_NONE)
                begin
                    cnt = 2'd1;
                    r0 = CH_LF;
                end
                held_nl = HELD_NONE;
            end
            ACT_DISCARD:
            begin
                held_nl = HELD_NONE;
            end
            ACT_DATA:
            begin
                case (model_mode)
                    MODE_DECODE:
                    begin
                        if (b == CH_LF || b == CH_CR)
                        begin
                            if (held_nl == HELD_NONE)
                                held_nl = self_nl;
                            else
                            begin
                                cnt = 2'd1;
                                r0 = CH_LF;
                                // a doubled newline stays held, a mixed pair is consumed
                                if (held_nl != self_nl)
                                    held_nl = HELD_NONE;
                            end
                        end
                        else if (held_nl != HELD_NONE)
                        begin
                            cnt = 2'd2;
                            r0 = CH_LF;
                            r1 = b;
                            held_nl = HELD_NONE;
                        end
                        else
                        begin
                            cnt = 2'd1;
                            r0 = b;
                        end
                    end
                    MODE_CRLF:
                    begin
                        if (b == CH_LF)
                        begin
                            cnt = 2'd2;
                            r0 = CH_CR;
                            r1 = CH_LF;
                        end
                        else if (b != CH_CR)
                        begin
                            cnt = 2'd1;
                            r0 = b;
                        end
                    end
                    MODE_LF:
                    begin
                        if (b != CH_CR)
                        begin
                            cnt = 2'd1;
                            r0 = b;
                        end
                    end
                    MODE_CR:
                    begin
                        if (b == CH_LF)
                        begin
                            cnt = 2'd1;
                            r0 = CH_CR;
                        end
                        else if (b != CH_CR)
                        begin
                            cnt = 2'd1;
                            r0 = b;
                        end
                    end
                    default:
                    begin
                        cnt = 2'd1;
                        r0 = b;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic flag_error(input string msg);
        if (mismatch_cnt < 10)
            $display("%0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // prediction on input transfers, checking on result transfers
    always @(posedge clk)
    begin : result_side
        logic [1:0] n;
        logic [7:0] r0;
        logic [7:0] r1;
        out_byte_t  want;
        if (rst_n)
        begin
            if (translate_mode_we)
                model_mode = translate_mode_wdata;
            if (push && !full)
            begin
                predict_translation(action, byte_in, n, r0, r1);
                if (row_known)
                begin
                    n = row_cnt;
                    r0 = row_e0;
                    r1 = row_e1;
                end
                if (n >= 2'd1)
                begin
                    want.byte_val = r0;
                    want.last_flag = (n == 2'd1);
                    out_bytes_q.push_back(want);
                end
                if (n == 2'd2)
                begin
                    want.byte_val = r1;
                    want.last_flag = 1'b1;
                    out_bytes_q.push_back(want);
                end
            end
            if (pop && !empty)
            begin
                if (out_bytes_q.size() == 0)
                    flag_error($sformatf("unexpected result byte_out=%02h last=%0b",
                                         byte_out, last));
                else
                begin
                    want = out_bytes_q.pop_front();
                    if (byte_out !== want.byte_val)
                        flag_error($sformatf("byte_out expected %02h actual %02h",
                                             want.byte_val, byte_out));
                    if (last !== want.last_flag)
                        flag_error($sformatf("last expected %0b actual %0b (byte %02h)",
                                             want.last_flag, last, want.byte_val));
                end
            end
        end
        pop <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_item(input logic [1:0] a, input logic [7:0] b, input logic k,
                             input logic [1:0] c, input logic [7:0] x0, input logic [7:0] x1);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        action <= a;
        byte_in <= b;
        row_known <= k;
        row_cnt <= c;
        row_e0 <= x0;
        row_e1 <= x1;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // hold off until every predicted byte has transferred and the pipe is quiet
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (out_bytes_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_mode(input logic [2:0] m);
        drain();
        translate_mode_we <= 1'b1;
        translate_mode_wdata <= m;
        @(posedge clk);
        translate_mode_we <= 1'b0;
    endtask

    task automatic add_step(input logic [2:0] m, input logic [1:0] a, input logic [7:0] d,
                            input logic k, input logic [1:0] c, input logic [7:0] x0,
                            input logic [7:0] x1);
        step_t s;
        s.mode = m;
        s.act = a;
        s.data = d;
        s.known = k;
        s.cnt = c;
        s.e0 = x0;
        s.e1 = x1;
        directed_q.push_back(s);
    endtask

    task automatic build_directed();
        add_step(MODE_DECODE, ACT_DATA,    8'h00, 1'b1, 2'd1, 8'h00,  8'h00);
        add_step(MODE_DECODE, ACT_DATA,    8'hFF, 1'b1, 2'd1, 8'hFF,  8'h00);
        add_step(MODE_DECODE, ACT_DATA,    CH_LF, 1'b1, 2'd0, 8'h00,  8'h00);
        add_step(MODE_DECODE, ACT_DATA,    CH_CR, 1'b1, 2'd1, CH_LF,  8'h00);
        add_step(MODE_DECODE, ACT_DATA,    CH_CR, 1'b1, 2'd0, 8'h00,  8'h00);
        add_step(MODE_DECODE, ACT_DATA,    CH_CR, 1'b0, 2'd0, 8'h00,  8'h00);
        add_step(MODE_DECODE, ACT_DATA,    CH_LF, 1'b0, 2'd0, 8'h00,  8'h00);
        add_step(MODE_DECODE, ACT_DATA,    CH_LF, 1'b1, 2'd0, 8'h00,  8'h00);
        add_step(MODE_DECODE, ACT_DATA,    CH_LF, 1'b0, 2'd0, 8'h00,  8'h00);
        add_step(MODE_DECODE, ACT_DATA,    8'h41, 1'b0, 2'd0, 8'h00,  8'h00);
        add_step(MODE_DECODE, ACT_DATA,    CH_CR, 1'b1, 2'd0, 8'h00,  8'h00);
        add_step(MODE_DECODE, ACT_EOF,     8'h00, 1'b1, 2'd1, CH_LF,  8'h00);
        add_step(MODE_DECODE, ACT_EOF,     8'hFF, 1'b1, 2'd0, 8'h00,  8'h00);
        add_step(MODE_DECODE, ACT_DATA,    CH_LF, 1'b1, 2'd0, 8'h00,  8'h00);
        add_step(MODE_DECODE, ACT_DISCARD, CH_LF, 1'b1, 2'd0, 8'h00,  8'h00);
        add_step(MODE_DECODE, ACT_DATA,    8'h41, 1'b1, 2'd1, 8'h41,  8'h00);
        add_step(MODE_DECODE, ACT_DATA,    CH_CR, 1'b1, 2'd0, 8'h00,  8'h00);
        // reserved action leaves the held CR alone
        add_step(MODE_DECODE, ACT_RSVD,    CH_CR, 1'b1, 2'd0, 8'h00,  8'h00);
        add_step(MODE_BINARY, ACT_DATA,    CH_LF, 1'b1, 2'd1, CH_LF,  8'h00);
        add_step(MODE_BINARY, ACT_EOF,     8'h00, 1'b1, 2'd0, 8'h00,  8'h00);
        add_step(MODE_DECODE, ACT_EOF,     8'h00, 1'b1, 2'd0, 8'h00,  8'h00);
        add_step(MODE_CRLF,   ACT_DATA,    CH_LF, 1'b1, 2'd2, CH_CR,  CH_LF);
        add_step(MODE_CRLF,   ACT_DATA,    CH_CR, 1'b1, 2'd0, 8'h00,  8'h00);
        add_step(MODE_LF,     ACT_DATA,    CH_CR, 1'b1, 2'd0, 8'h00,  8'h00);
        add_step(MODE_LF,     ACT_DATA,    CH_LF, 1'b1, 2'd1, CH_LF,  8'h00);
        add_step(MODE_CR,     ACT_DATA,    CH_LF, 1'b1, 2'd1, CH_CR,  8'h00);
        add_step(MODE_CR,     ACT_DATA,    CH_CR, 1'b1, 2'd0, 8'h00,  8'h00);
        add_step(MODE_RSVD7,  ACT_DATA,    CH_CR, 1'b1, 2'd1, CH_CR,  8'h00);
    endtask

    function automatic logic [2:0] segment_mode(input int seg);
        case (seg)
            0:       return MODE_DECODE;
            1:       return MODE_CRLF;
            2:       return MODE_DECODE;
            3:       return MODE_RSVD7;
            4:       return MODE_LF;
            5:       return MODE_DECODE;
            6:       return MODE_CR;
            7:       return MODE_BINARY;
            8:       return MODE_RSVD5;
            9:       return MODE_RSVD6;
            default: return MODE_DECODE;
        endcase
    endfunction

    // newline heavy text with a sprinkling of flushes, discards and reserved actions
    task automatic pick_item(output logic [1:0] a, output logic [7:0] b);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            a = ACT_EOF;
        else if (r < 7)
            a = ACT_DISCARD;
        else if (r < 9)
            a = ACT_RSVD;
        else
            a = ACT_DATA;
        r = $urandom_range(99);
        if (r < 30)
            b = CH_LF;
        else if (r < 60)
            b = CH_CR;
        else
            b = 8'($urandom_range(255));
    endtask

    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        step_t      s;
        logic [2:0] drv_mode;
        logic [1:0] a;
        logic [7:0] b;
        int         sent;
        drv_mode = MODE_DECODE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_directed();
        for (int i = 0; i < directed_q.size(); i++)
        begin
            s = directed_q[i];
            if (s.mode != drv_mode)
            begin
                set_mode(s.mode);
                drv_mode = s.mode;
            end
            send_item(s.act, s.data, s.known, s.cnt, s.e0, s.e1);
        end

        for (int seg = 0; seg < SEG_COUNT; seg++)
        begin
            set_mode(segment_mode(seg));
            case (seg % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 61;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 61;
                end
                default:
                begin
                    idle_pct = 14;
                    stall_pct = 14;
                end
            endcase
            sent = 0;
            while (sent < SEG_ITEMS)
            begin
                pick_item(a, b);
                send_item(a, b, 1'b0, 2'd0, 8'h00, 8'h00);
                if (a != ACT_RSVD)
                    sent++;
            end
        end

        drain();
        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
